>>> rtl/htg_pkg.sv
`default_nettype none
package htg_pkg;

	localparam int CHANNELS = 3;
	localparam int CHAN_W = 20;
	localparam int GAIN_W = 12;
	localparam int COUNT_W = 3;
	localparam int PROD_W = CHAN_W + GAIN_W;
	localparam int FRAC_W = 16;
	localparam int BYTE_W = 8;
	localparam int DEF_INPUT_FRAC_BITS = 12;
	localparam int DEF_GAMMA_INDEX_BITS = 10;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd3;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_EXPOSURE_GAIN = 1'b0,
		REG_CHANNEL_COUNT = 1'b1
	} reg_idx_t;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  exposure_gain;
		logic [COUNT_W-1:0] channel_count;
	} cfg_t;

	// largest v with v^11 * 2^(5g) <= i^5 * 255^11, evaluated at elaboration only
	function automatic byte_t gamma_entry(input int g, input int i);
		logic [191:0] rhs;
		logic [191:0] lhs;
		byte_t        v;
		byte_t        c;
		rhs = 192'd1;
		for (int k = 0; k < 5; k++) rhs = rhs * 192'(i);
		for (int k = 0; k < 11; k++) rhs = rhs * 192'd255;
		v = '0;
		for (int b = 7; b >= 0; b--) begin
			c = v | byte_t'(1 << b);
			lhs = 192'd1;
			for (int k = 0; k < 11; k++) lhs = lhs * 192'(c);
			lhs = lhs << (5 * g);
			if (lhs <= rhs) v = c;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

>>> rtl/htg_expose.sv
`default_nettype none
module htg_expose #(
	parameter int INPUT_FRAC_BITS = htg_pkg::DEF_INPUT_FRAC_BITS
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                valid_in,
	input  wire htg_pkg::chan_t chan_in [htg_pkg::CHANNELS],
	input  wire htg_pkg::cfg_t cfg,
	output logic               valid_s2,
	output htg_pkg::chan_t     exp_s2 [htg_pkg::CHANNELS],
	output logic [htg_pkg::CHAN_W:0] den_s2 [htg_pkg::CHANNELS]
);
	import htg_pkg::*;

	localparam logic [CHAN_W:0] ONE = (CHAN_W+1)'(1) << INPUT_FRAC_BITS;

	logic              valid_s1;
	logic [PROD_W-1:0] prod_s1 [CHANNELS];
	logic [PROD_W-9:0] scaled  [CHANNELS];
	chan_t             sat     [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// drop channels beyond the configured count, then scale by the gain
	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		always_ff @(posedge clk) begin
			if (cfg.channel_count > COUNT_W'(c))
				prod_s1[c] <= PROD_W'(chan_in[c]) * PROD_W'(cfg.exposure_gain);
			else
				prod_s1[c] <= '0;
		end

		always_comb begin
			scaled[c] = prod_s1[c][PROD_W-1:8];
			if (scaled[c] > (PROD_W-8)'({CHAN_W{1'b1}}))
				sat[c] = '1;
			else
				sat[c] = scaled[c][CHAN_W-1:0];
		end

		always_ff @(posedge clk) begin
			exp_s2[c] <= sat[c];
			den_s2[c] <= {1'b0, sat[c]} + ONE;
		end
	end

endmodule
`default_nettype wire

>>> rtl/htg_reinhard.sv
`default_nettype none
module htg_reinhard (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        valid_in,
	input  wire htg_pkg::chan_t        exp_in [htg_pkg::CHANNELS],
	input  wire [htg_pkg::CHAN_W:0]    den_in [htg_pkg::CHANNELS],
	output logic                       valid_out,
	output logic [htg_pkg::FRAC_W-1:0] frac_out [htg_pkg::CHANNELS]
);
	import htg_pkg::*;

	// one quotient bit per stage; the remainder starts at e since e < e + 1.0
	logic              vld_s [FRAC_W+1];
	logic [CHAN_W:0]   rem_s [FRAC_W+1][CHANNELS];
	logic [CHAN_W:0]   den_s [FRAC_W+1][CHANNELS];
	logic [FRAC_W-1:0] quo_s [FRAC_W+1][CHANNELS];

	assign vld_s[0] = valid_in;

	for (genvar c = 0; c < CHANNELS; c++) begin : g_in
		assign rem_s[0][c] = {1'b0, exp_in[c]};
		assign den_s[0][c] = den_in[c];
		assign quo_s[0][c] = '0;
		assign frac_out[c] = quo_s[FRAC_W][c];
	end

	for (genvar k = 0; k < FRAC_W; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else         vld_s[k+1] <= vld_s[k];
		end

		for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
			logic [CHAN_W+1:0] trial;
			logic [CHAN_W+1:0] diff;
			logic              fits;
			assign trial = {rem_s[k][c], 1'b0};
			assign diff  = trial - {1'b0, den_s[k][c]};
			assign fits  = trial >= {1'b0, den_s[k][c]};

			always_ff @(posedge clk) begin
				if (fits) rem_s[k+1][c] <= diff[CHAN_W:0];
				else      rem_s[k+1][c] <= trial[CHAN_W:0];
				den_s[k+1][c] <= den_s[k][c];
				quo_s[k+1][c] <= {quo_s[k][c][FRAC_W-2:0], fits};
			end
		end
	end

	assign valid_out = vld_s[FRAC_W];

endmodule
`default_nettype wire

>>> rtl/htg_gamma.sv
`default_nettype none
module htg_gamma #(
	parameter int GAMMA_INDEX_BITS = htg_pkg::DEF_GAMMA_INDEX_BITS
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        valid_in,
	input  wire [htg_pkg::FRAC_W-1:0]  frac_in [htg_pkg::CHANNELS],
	output logic                       valid_q,
	output htg_pkg::byte_t             byte_q [htg_pkg::CHANNELS]
);
	import htg_pkg::*;

	localparam int ROM_SIZE = 1 << GAMMA_INDEX_BITS;

	byte_t rom [ROM_SIZE];

	for (genvar gi = 0; gi < ROM_SIZE; gi++) begin : g_rom
		localparam byte_t ENTRY = gamma_entry(GAMMA_INDEX_BITS, gi);
		assign rom[gi] = ENTRY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else         valid_q <= valid_in;
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		always_ff @(posedge clk) begin
			byte_q[c] <= rom[frac_in[c][FRAC_W-1 -: GAMMA_INDEX_BITS]];
		end
	end

endmodule
`default_nettype wire

>>> rtl/hdr_tonemap_gamma_rgb8.sv
`default_nettype none
// Channel   | Direction | Handshake               | Words
// ----------+-----------+-------------------------+-------------------------------
// texel in  | in        | start, busy (always low) | red_in, green_in, blue_in
// result    | out       | done strobe, one cycle   | red_out, green_out, blue_out
// config    | in/out    | APB, pready always high  | 0x0 exposure_gain, 0x4 channel_count
//
// One word may enter every cycle. Masking, gain multiply and saturation are
// registered in stages s1 and s2, the Reinhard divider yields one quotient bit
// per stage, and the gamma ROM registers the output word.
// Reset clears the valid chain and loads gain 1.0 and three channels.
// The receiver cannot stall, so the pipeline always advances and busy stays low.
module hdr_tonemap_gamma_rgb8 #(
	parameter int INPUT_FRAC_BITS  = htg_pkg::DEF_INPUT_FRAC_BITS,
	parameter int GAMMA_INDEX_BITS = htg_pkg::DEF_GAMMA_INDEX_BITS
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire [htg_pkg::CHAN_W-1:0]         red_in,
	input  wire [htg_pkg::CHAN_W-1:0]         green_in,
	input  wire [htg_pkg::CHAN_W-1:0]         blue_in,
	output logic                              done,
	output logic [htg_pkg::BYTE_W-1:0]        red_out,
	output logic [htg_pkg::BYTE_W-1:0]        green_out,
	output logic [htg_pkg::BYTE_W-1:0]        blue_out,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire [htg_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire [htg_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [htg_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import htg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     wr_en;

	chan_t          chan_in [CHANNELS];
	logic           vld_exp;
	chan_t          exp_w   [CHANNELS];
	logic [CHAN_W:0] den_w  [CHANNELS];
	logic           vld_div;
	logic [FRAC_W-1:0] frac_w [CHANNELS];
	byte_t          byte_w  [CHANNELS];

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// decode the word address; byte offsets are ignored
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exposure_gain <= GAIN_RESET;
			cfg_q.channel_count <= COUNT_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_EXPOSURE_GAIN: cfg_q.exposure_gain <= pwdata[GAIN_W-1:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_EXPOSURE_GAIN: prdata = APB_DATA_W'(cfg_q.exposure_gain);
			REG_CHANNEL_COUNT: prdata = APB_DATA_W'(cfg_q.channel_count);
			default:           prdata = '0;
		endcase
	end

	assign chan_in[0] = red_in;
	assign chan_in[1] = green_in;
	assign chan_in[2] = blue_in;

	// mask, expose and saturate
	htg_expose #(
		.INPUT_FRAC_BITS(INPUT_FRAC_BITS)
	) u_expose (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (start),
		.chan_in  (chan_in),
		.cfg      (cfg_q),
		.valid_s2 (vld_exp),
		.exp_s2   (exp_w),
		.den_s2   (den_w)
	);

	// x / (1 + x) as a 16-bit fraction
	htg_reinhard u_reinhard (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (vld_exp),
		.exp_in    (exp_w),
		.den_in    (den_w),
		.valid_out (vld_div),
		.frac_out  (frac_w)
	);

	// gamma 2.2 lookup, registered output word
	htg_gamma #(
		.GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)
	) u_gamma (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (vld_div),
		.frac_in  (frac_w),
		.valid_q  (done),
		.byte_q   (byte_w)
	);

	assign red_out   = byte_w[0];
	assign green_out = byte_w[1];
	assign blue_out  = byte_w[2];

endmodule
`default_nettype wire

>>> dv/tonemap_checker.sv
`timescale 1ns / 1ps
module tonemap_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [19:0] red_in,
	input  logic [19:0] green_in,
	input  logic [19:0] blue_in,
	input  logic       done,
	input  logic [7:0] red_out,
	input  logic [7:0] green_out,
	input  logic [7:0] blue_out,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [htg_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	input  logic       pready,
	output int         fail_count,
	output int         pending
);
	import htg_pkg::*;

	localparam int FRAC_BITS = DEF_INPUT_FRAC_BITS;
	localparam int IDX_BITS = DEF_GAMMA_INDEX_BITS;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	logic [11:0] gain;
	logic [2:0]  chans;
	logic [7:0]  gamma_lut [0:(1<<IDX_BITS)-1];
	rgb_t        expected_rgb [$];

	// exact root by search on wide integers
	function automatic logic [7:0] gamma_of(int i);
		logic [191:0] rhs, lhs;
		int v;
		rhs = 1;
		for (int k = 0; k < 5; k++) rhs = rhs * i;
		for (int k = 0; k < 11; k++) rhs = rhs * 255;
		v = 0;
		while (v < 255) begin
			lhs = 1;
			for (int k = 0; k < 11; k++) lhs = lhs * (v + 1);
			lhs = lhs << (5 * IDX_BITS);
			if (lhs > rhs) break;
			v++;
		end
		return v[7:0];
	endfunction

	function automatic logic [7:0] tone_byte(logic [19:0] x);
		logic [63:0] e, t;
		e = ({44'd0, x} * gain) >> 8;
		if (e > 64'hFFFFF) e = 64'hFFFFF;
		t = (e << 16) / (e + (64'd1 << FRAC_BITS));
		return gamma_lut[t[15:16-IDX_BITS]];
	endfunction

	initial begin
		for (int i = 0; i < (1 << IDX_BITS); i++) gamma_lut[i] = gamma_of(i);
	end

	assign pending = expected_rgb.size();

	always @(posedge clk or negedge arst_n) begin
		rgb_t p, w;
		logic [19:0] r, g, b;
		if (!arst_n) begin
			gain <= GAIN_RESET;
			chans <= COUNT_RESET;
			fail_count <= 0;
			expected_rgb.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (reg_idx_t'(paddr[2]) == REG_EXPOSURE_GAIN) gain <= pwdata[11:0];
				else chans <= pwdata[2:0];
			end
			if (done) begin
				if (expected_rgb.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10) $display("unexpected word %h %h %h",
						red_out, green_out, blue_out);
				end else begin
					w = expected_rgb.pop_front();
					if (w.r !== red_out || w.g !== green_out || w.b !== blue_out) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected %h %h %h got %h %h %h",
								w.r, w.g, w.b, red_out, green_out, blue_out);
					end
				end
			end
			if (start && !busy) begin
				r = (chans >= 1) ? red_in : '0;
				g = (chans >= 2) ? green_in : '0;
				b = (chans >= 3) ? blue_in : '0;
				p.r = tone_byte(r);
				p.g = tone_byte(g);
				p.b = tone_byte(b);
				expected_rgb = {expected_rgb, p};
			end
		end
	end
endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import htg_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, pready;
	logic [19:0] red_in = '0, green_in = '0, blue_in = '0;
	logic [7:0] red_out, green_out, blue_out;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	int fail_count, pending;
	int idle_pct;

	always #10 clk = ~clk;

	hdr_tonemap_gamma_rgb8 u_top (.*);

	tonemap_checker u_chk (.*);

	// give up long after the slowest correct run
	initial begin
		#5ms;
		$display("[hdr_tonemap_gamma_rgb8] ERROR");
		$finish;
	end

	// register write with setup and access phases; hold the bus idle afterwards
	task automatic reg_write(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// drain results, then let the pipeline empty before touching registers
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	// offer one word; hold start until it is taken
	task automatic send_word(logic [19:0] r, logic [19:0] g, logic [19:0] b);
		while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		red_in <= r; green_in <= g; blue_in <= b;
		do @(posedge clk); while (busy);
	endtask

	// mostly realistic radiance, with some extremes and full-range noise
	function automatic logic [19:0] rand_chan();
		case ($urandom_range(5, 0))
			0: return 20'($urandom_range(32'hFFFFF, 0));
			1: return 20'($urandom_range(255, 0));
			2: return 20'hFFFFF - 20'($urandom_range(255, 0));
			default: return 20'($urandom_range(32'h4000, 0));
		endcase
	endfunction

	initial begin
		logic [11:0] gains [6];
		gains = '{12'd26, 12'd2560, 12'd0, 12'hFFF, 12'd256, 12'd100};
		idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes under reset settings
		send_word('0, '0, '0);
		send_word(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		send_word(20'h01000, 20'h00001, 20'h80000);
		send_word(20'h55555, 20'hAAAAA, 20'h0F0F0);
		settle();
		// every channel count, including the ones above three
		for (int c = 0; c < 8; c++) begin
			reg_write(REG_CHANNEL_COUNT, c);
			send_word(20'hFFFFF, 20'h01000, 20'h7FFFF);
			settle();
		end
		reg_write(REG_CHANNEL_COUNT, 3);
		// exposure zero, range ends and above range
		foreach (gains[k]) begin
			reg_write(REG_EXPOSURE_GAIN, gains[k]);
			send_word(20'hFFFFF, 20'h00100, 20'h01000);
			settle();
		end

		// random phases, each writing its own settings; each pair of phases shares an idle rate
		for (int ph = 0; ph < 6; ph++) begin
			reg_write(REG_EXPOSURE_GAIN, (ph == 0) ? 26 : (ph == 1) ? 2560 :
				$urandom_range(4095, 0));
			reg_write(REG_CHANNEL_COUNT, (ph % 3 == 2) ? $urandom_range(7, 0) : 3);
			idle_pct = (ph < 2) ? 28 : (ph < 4) ? 76 : 0;
			for (int n = 0; n < 165; n++) send_word(rand_chan(), rand_chan(), rand_chan());
			settle();
		end

		if (fail_count == 0) $display("[hdr_tonemap_gamma_rgb8] OK");
		else $display("[hdr_tonemap_gamma_rgb8] ERROR");
		$finish;
	end
endmodule
